FILE: hw/rtl/a2b_pkg.sv
// ----------------------------------------------------------------------------
// a2b_pkg
// Types and constants shared by the AVCC to Annex B converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package a2b_pkg;

    // input request: one byte of extradata or packet payload
    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
        logic       last_byte;
    } a2b_in_t;

    // output request: one Annex B byte or a status-only result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       packet_end;
        logic       idr_flag;
        logic [2:0] error_code;
    } a2b_out_t;

    typedef enum logic [0:0] {
        MODE_EXTRA  = 1'b0,
        MODE_PACKET = 1'b1
    } a2b_mode_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNC_LEN = 3'd1,
        ERR_NAL_LEN   = 3'd2,
        ERR_BAD_EXTRA = 3'd3,
        ERR_OVERFLOW  = 3'd4
    } a2b_err_t;

    // extradata parser phase
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COUNT,
        PH_SIZE_HI,
        PH_SIZE_LO,
        PH_DATA,
        PH_DONE,
        PH_FAILED
    } a2b_phase_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SC_WR,
        ST_PSET_RD,
        ST_PSET_WR,
        ST_START,
        ST_TAIL
    } a2b_state_t;

    localparam int unsigned HEADER_BYTES  = 5;
    localparam logic [7:0]  COUNT_MASK    = 8'h1f;
    localparam logic [4:0]  NAL_TYPE_IDR  = 5'd5;
    localparam int unsigned START_BYTES   = 4;

    // results planned for one accepted byte
    typedef struct packed {
        logic       sc_write;    // store start code in the parameter-set memory
        logic       pset;        // replay stored parameter sets
        logic       start_en;    // emit a start code
        logic       start_four;  // 4-byte start code
        logic       tail;        // data byte or status result follows
        logic       tail_byte;   // tail carries a data byte
        logic [7:0] tail_val;
        a2b_err_t   err;
        logic       pend;
        logic       key;
    } a2b_plan_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic out_direct;
        logic sc_write;
        logic rd_issue;
        logic out_pset;
        logic out_start;
        logic out_tail;
    } a2b_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic slot_free;
        logic c_sc_write;
        logic c_pset;
        logic c_start;
        logic c_tail;
        logic p_tail;
        logic pset_last;
        logic start_last;
        logic sc_last;
    } a2b_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/a2b_dp.sv
// ----------------------------------------------------------------------------
// a2b_dp
// Datapath: parser state, parameter-set memory, result planning and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_dp #(
    parameter int unsigned PSET_MAX = 56
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  a2b_pkg::a2b_in_t    src_item,
    input  wire                 dst_ready,
    input  a2b_pkg::a2b_cmd_t   cmd,
    output a2b_pkg::a2b_stat_t  stat,
    output logic                dst_valid,
    output a2b_pkg::a2b_out_t   dst_item
);
    import a2b_pkg::*;

    localparam int unsigned FILL_W = $clog2(PSET_MAX + 1);
    localparam int unsigned ADDR_W = $clog2(PSET_MAX);

    // parameter-set memory
    logic [7:0] mem [PSET_MAX];
    logic [7:0] mem_q_reg;

    // extradata state
    logic [FILL_W-1:0] pset_fill_reg, pset_fill_next;
    a2b_phase_t        extra_phase_reg, extra_phase_next;
    logic [2:0]        extra_pos_reg, extra_pos_next;
    logic [7:0]        units_left_reg, units_left_next;
    logic [15:0]       unit_bytes_left_reg, unit_bytes_left_next;
    logic              seen_pps_reg, seen_pps_next;

    // packet state
    logic [31:0]       len_shift_reg, len_shift_next;
    logic [2:0]        len_count_reg, len_count_next;
    logic [30:0]       nal_left_reg, nal_left_next;
    logic              first_nal_reg, first_nal_next;
    logic              key_seen_reg, key_seen_next;
    logic              skip_reg, skip_next;

    // sequencing
    a2b_plan_t         plan_c, plan_reg;
    logic [FILL_W-1:0] pset_idx_reg;
    logic [1:0]        start_cnt_reg;
    logic [FILL_W-1:0] sc_base_reg;
    logic [1:0]        sc_idx_reg;

    logic              out_valid_reg;
    a2b_out_t          out_item_reg;

    logic              wr_en;
    logic [FILL_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    function automatic a2b_out_t tail_item(input a2b_plan_t p);
        a2b_out_t o;
        o.out_byte   = p.tail_byte ? p.tail_val : 8'h00;
        o.byte_valid = p.tail_byte;
        o.run_last   = 1'b1;
        o.packet_end = p.pend;
        o.idr_flag   = p.key;
        o.error_code = p.err;
        return o;
    endfunction

    // next state and result plan for the presented byte
    always_comb
    begin
        logic [7:0]  b;
        logic        last;
        logic [7:0]  cnt;
        logic [15:0] ubv;
        logic [17:0] need;
        logic [15:0] ubd;
        logic [7:0]  u1;
        logic        fin;
        logic [31:0] ls;
        logic [2:0]  lc;
        logic [30:0] nald;

        b    = src_item.in_byte;
        last = src_item.last_byte;
        cnt  = 8'h00;
        ubv  = 16'h0000;
        need = 18'd0;
        ubd  = 16'h0000;
        u1   = 8'h00;
        fin  = 1'b0;
        ls   = 32'h0;
        lc   = 3'd0;
        nald = 31'h0;

        pset_fill_next       = pset_fill_reg;
        extra_phase_next     = extra_phase_reg;
        extra_pos_next       = extra_pos_reg;
        units_left_next      = units_left_reg;
        unit_bytes_left_next = unit_bytes_left_reg;
        seen_pps_next        = seen_pps_reg;
        len_shift_next       = len_shift_reg;
        len_count_next       = len_count_reg;
        nal_left_next        = nal_left_reg;
        first_nal_next       = first_nal_reg;
        key_seen_next        = key_seen_reg;
        skip_next            = skip_reg;
        plan_c               = '0;
        plan_c.err           = ERR_NONE;
        wr_en                = 1'b0;
        wr_addr              = sc_base_reg + FILL_W'(sc_idx_reg);
        wr_data              = (sc_idx_reg == 2'd3) ? 8'h01 : 8'h00;

        if (src_item.mode == MODE_EXTRA)
        begin
            unique case (extra_phase_reg)
                PH_HEADER:
                begin
                    if (extra_pos_reg == 3'd0)
                        pset_fill_next = '0;
                    extra_pos_next = extra_pos_reg + 3'd1;
                    if (extra_pos_next >= 3'(HEADER_BYTES))
                    begin
                        extra_pos_next   = 3'd0;
                        seen_pps_next    = 1'b0;
                        extra_phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    cnt = seen_pps_reg ? b : (b & COUNT_MASK);
                    if (cnt == 8'h00)
                    begin
                        if (!seen_pps_reg)
                            seen_pps_next = 1'b1;
                        else
                            extra_phase_next = PH_DONE;
                    end
                    else
                    begin
                        units_left_next  = cnt;
                        extra_phase_next = PH_SIZE_HI;
                    end
                end
                PH_SIZE_HI:
                begin
                    unit_bytes_left_next = {b, 8'h00};
                    extra_phase_next     = PH_SIZE_LO;
                end
                PH_SIZE_LO:
                begin
                    ubv = {unit_bytes_left_reg[15:8], b};
                    unit_bytes_left_next = ubv;
                    need = 18'(pset_fill_reg) + 18'(START_BYTES) + 18'(ubv);
                    if (need > 18'(PSET_MAX))
                    begin
                        pset_fill_next   = '0;
                        extra_phase_next = PH_FAILED;
                        plan_c.err       = ERR_OVERFLOW;
                    end
                    else
                    begin
                        plan_c.sc_write = 1'b1;
                        pset_fill_next  = pset_fill_reg + FILL_W'(START_BYTES);
                        if (ubv == 16'h0000)
                            fin = 1'b1;
                        else
                            extra_phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (pset_fill_reg < FILL_W'(PSET_MAX))
                    begin
                        wr_en          = cmd.accept;
                        wr_addr        = pset_fill_reg;
                        wr_data        = b;
                        pset_fill_next = pset_fill_reg + FILL_W'(1);
                    end
                    ubd = (unit_bytes_left_reg != 16'h0000) ?
                          unit_bytes_left_reg - 16'd1 : unit_bytes_left_reg;
                    unit_bytes_left_next = ubd;
                    if (ubd == 16'h0000)
                        fin = 1'b1;
                end
                default:
                begin
                end
            endcase

            // end of one parameter set
            if (fin)
            begin
                u1 = (units_left_reg != 8'h00) ? units_left_reg - 8'd1 : 8'h00;
                units_left_next = u1;
                if (u1 != 8'h00)
                    extra_phase_next = PH_SIZE_HI;
                else if (!seen_pps_reg)
                begin
                    seen_pps_next    = 1'b1;
                    extra_phase_next = PH_COUNT;
                end
                else
                    extra_phase_next = PH_DONE;
            end

            // end of the extradata block
            if (last)
            begin
                if (extra_phase_next != PH_DONE && extra_phase_next != PH_FAILED)
                begin
                    pset_fill_next = '0;
                    plan_c.err     = ERR_BAD_EXTRA;
                end
                plan_c.pend          = 1'b1;
                extra_phase_next     = PH_HEADER;
                extra_pos_next       = 3'd0;
                units_left_next      = 8'h00;
                unit_bytes_left_next = 16'h0000;
                seen_pps_next        = 1'b0;
            end
            plan_c.tail = last || (plan_c.err != ERR_NONE);
        end
        else
        begin
            if (skip_reg)
            begin
                // dropped until packet end
            end
            else if (len_count_reg < 3'd4)
            begin
                ls = (len_count_reg == 3'd0) ? {24'h0, b} : {len_shift_reg[23:0], b};
                lc = len_count_reg + 3'd1;
                len_shift_next = ls;
                len_count_next = lc;
                if (lc == 3'd4)
                begin
                    if (ls[31])
                    begin
                        len_count_next = 3'd0;
                        skip_next      = 1'b1;
                        plan_c.err     = ERR_NAL_LEN;
                    end
                    else if (ls == 32'h0)
                    begin
                        plan_c.start_en   = 1'b1;
                        plan_c.start_four = first_nal_reg;
                        first_nal_next    = 1'b0;
                        len_count_next    = 3'd0;
                    end
                    else
                        nal_left_next = ls[30:0];
                end
                else if (last)
                    plan_c.err = ERR_TRUNC_LEN;
            end
            else
            begin
                if (nal_left_reg == len_shift_reg[30:0])
                begin
                    if (b[4:0] == NAL_TYPE_IDR)
                    begin
                        key_seen_next = 1'b1;
                        plan_c.pset   = (pset_fill_reg != '0);
                    end
                    plan_c.start_en   = 1'b1;
                    plan_c.start_four = first_nal_reg;
                    first_nal_next    = 1'b0;
                end
                plan_c.tail_byte = 1'b1;
                plan_c.tail_val  = b;
                nald = (nal_left_reg != 31'h0) ? nal_left_reg - 31'd1 : nal_left_reg;
                nal_left_next = nald;
                if (nald == 31'h0)
                begin
                    len_count_next = 3'd0;
                    len_shift_next = 32'h0;
                end
            end

            // end of the packet
            if (last)
            begin
                if (!skip_next && len_count_next == 3'd4 && nal_left_next != 31'h0)
                    plan_c.err = ERR_NAL_LEN;
                plan_c.pend    = 1'b1;
                plan_c.key     = key_seen_next;
                len_shift_next = 32'h0;
                len_count_next = 3'd0;
                nal_left_next  = 31'h0;
                first_nal_next = 1'b1;
                key_seen_next  = 1'b0;
                skip_next      = 1'b0;
            end
            plan_c.tail = plan_c.tail_byte ||
                          ((last || plan_c.err != ERR_NONE) && !plan_c.start_en);
        end

        if (cmd.sc_write)
        begin
            wr_en   = 1'b1;
            wr_addr = sc_base_reg + FILL_W'(sc_idx_reg);
            wr_data = (sc_idx_reg == 2'd3) ? 8'h01 : 8'h00;
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pset_fill_reg       <= '0;
            extra_phase_reg     <= PH_HEADER;
            extra_pos_reg       <= 3'd0;
            units_left_reg      <= 8'h00;
            unit_bytes_left_reg <= 16'h0000;
            seen_pps_reg        <= 1'b0;
            len_shift_reg       <= 32'h0;
            len_count_reg       <= 3'd0;
            nal_left_reg        <= 31'h0;
            first_nal_reg       <= 1'b1;
            key_seen_reg        <= 1'b0;
            skip_reg            <= 1'b0;
            plan_reg            <= '0;
            pset_idx_reg        <= '0;
            start_cnt_reg       <= 2'd0;
            sc_base_reg         <= '0;
            sc_idx_reg          <= 2'd0;
        end
        else
        begin
            if (cmd.accept)
            begin
                pset_fill_reg       <= pset_fill_next;
                extra_phase_reg     <= extra_phase_next;
                extra_pos_reg       <= extra_pos_next;
                units_left_reg      <= units_left_next;
                unit_bytes_left_reg <= unit_bytes_left_next;
                seen_pps_reg        <= seen_pps_next;
                len_shift_reg       <= len_shift_next;
                len_count_reg       <= len_count_next;
                nal_left_reg        <= nal_left_next;
                first_nal_reg       <= first_nal_next;
                key_seen_reg        <= key_seen_next;
                skip_reg            <= skip_next;
                plan_reg            <= plan_c;
                pset_idx_reg        <= '0;
                start_cnt_reg       <= plan_c.start_four ? 2'd3 : 2'd2;
                sc_base_reg         <= pset_fill_reg;
                sc_idx_reg          <= 2'd0;
            end
            if (cmd.sc_write)
                sc_idx_reg <= sc_idx_reg + 2'd1;
            if (cmd.out_pset)
                pset_idx_reg <= pset_idx_reg + FILL_W'(1);
            if (cmd.out_start)
                start_cnt_reg <= start_cnt_reg - 2'd1;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[ADDR_W-1:0]] <= wr_data;
        if (cmd.rd_issue)
            mem_q_reg <= mem[pset_idx_reg[ADDR_W-1:0]];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_direct || cmd.out_pset || cmd.out_start || cmd.out_tail)
            out_valid_reg <= 1'b1;
        else if (dst_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.out_direct)
            out_item_reg <= tail_item(plan_c);
        else if (cmd.out_tail)
            out_item_reg <= tail_item(plan_reg);
        else if (cmd.out_pset)
            out_item_reg <= '{out_byte: mem_q_reg, byte_valid: 1'b1, run_last: 1'b0,
                              packet_end: 1'b0, idr_flag: 1'b0, error_code: ERR_NONE};
        else if (cmd.out_start)
        begin
            out_item_reg.out_byte   <= (start_cnt_reg == 2'd0) ? 8'h01 : 8'h00;
            out_item_reg.byte_valid <= 1'b1;
            if (start_cnt_reg == 2'd0 && !plan_reg.tail)
            begin
                out_item_reg.run_last   <= 1'b1;
                out_item_reg.packet_end <= plan_reg.pend;
                out_item_reg.idr_flag   <= plan_reg.key;
                out_item_reg.error_code <= plan_reg.err;
            end
            else
            begin
                out_item_reg.run_last   <= 1'b0;
                out_item_reg.packet_end <= 1'b0;
                out_item_reg.idr_flag   <= 1'b0;
                out_item_reg.error_code <= ERR_NONE;
            end
        end
    end

    // status to controller
    always_comb
    begin
        stat.slot_free  = !out_valid_reg || dst_ready;
        stat.c_sc_write = plan_c.sc_write;
        stat.c_pset     = plan_c.pset;
        stat.c_start    = plan_c.start_en;
        stat.c_tail     = plan_c.tail;
        stat.p_tail     = plan_reg.tail;
        stat.pset_last  = (pset_idx_reg + FILL_W'(1)) == pset_fill_reg;
        stat.start_last = (start_cnt_reg == 2'd0);
        stat.sc_last    = (sc_idx_reg == 2'd3);
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/a2b_ctrl.sv
// ----------------------------------------------------------------------------
// a2b_ctrl
// Controller: accepts bytes and sequences the results of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 src_valid,
    output logic                src_ready,
    input  a2b_pkg::a2b_stat_t  stat,
    output a2b_pkg::a2b_cmd_t   cmd
);
    import a2b_pkg::*;

    a2b_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        src_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                src_ready = stat.slot_free;
                if (src_valid && stat.slot_free)
                begin
                    cmd.accept = 1'b1;
                    cmd.out_direct = !stat.c_pset && !stat.c_start && stat.c_tail;
                    priority if (stat.c_sc_write)
                        state_next = ST_SC_WR;
                    else if (stat.c_pset)
                        state_next = ST_PSET_RD;
                    else if (stat.c_start)
                        state_next = ST_START;
                end
            end
            ST_SC_WR:
            begin
                cmd.sc_write = 1'b1;
                if (stat.sc_last)
                    state_next = ST_IDLE;
            end
            ST_PSET_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_PSET_WR;
            end
            ST_PSET_WR:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_pset = 1'b1;
                    state_next   = stat.pset_last ? ST_START : ST_PSET_RD;
                end
            end
            ST_START:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_start = 1'b1;
                    if (stat.start_last)
                        state_next = stat.p_tail ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_tail = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/avcc_to_annexb_nal_converter_core.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_nal_converter_core
// AVCC length-prefixed H.264 to Annex B start-code stream converter.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  --------+----------------------------------+---------------------------
//  src     | src_valid, src_ready, src_item   | mode, in_byte, last_byte
//  dst     | dst_valid, dst_ready, dst_item   | out_byte .. error_code
//
//  A byte with at most one result loads it into the output register on
//  acceptance. A start code adds 3 or 4 bytes plus the data byte or status
//  behind it; a type-5 unit replays the stored parameter-set bytes (memory
//  read then output load); a parameter-set size writes a 4-byte start code
//  into the store. Reset clears all control state; the store needs no
//  clearing. A stalled dst holds the output register and keeps src_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module avcc_to_annexb_nal_converter_core #(
    parameter int unsigned PSET_MAX = 56
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 src_valid,
    output logic                src_ready,
    input  a2b_pkg::a2b_in_t    src_item,
    output logic                dst_valid,
    input  wire                 dst_ready,
    output a2b_pkg::a2b_out_t   dst_item
);
    import a2b_pkg::*;

    a2b_cmd_t  cmd;
    a2b_stat_t stat;

    // control
    a2b_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    a2b_dp #(
        .PSET_MAX (PSET_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_item  (src_item),
        .dst_ready (dst_ready),
        .cmd       (cmd),
        .stat      (stat),
        .dst_valid (dst_valid),
        .dst_item  (dst_item)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/a2b_checker.sv
// ----------------------------------------------------------------------------
// a2b_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                src_ready,
    input wire                dst_valid,
    input wire                dst_ready,
    input a2b_pkg::a2b_out_t  dst_item
);
    import a2b_pkg::*;

    // a pending result holds until taken
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_item))
        else $error("result dropped or changed while stalled");

    // a byte is taken only when the output slot can move
    a_src_slot: assert property (@(posedge clk) disable iff (!rst_n)
        src_ready |-> !dst_valid || dst_ready)
        else $error("input taken while output blocked");

    // packet end closes the run of one byte
    a_pend_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_item.packet_end |-> dst_item.run_last)
        else $error("packet end without run end");

    // idr flag and error codes only at run end
    a_key_err: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && (dst_item.idr_flag || dst_item.error_code != ERR_NONE)
        |-> dst_item.run_last && dst_item.error_code <= ERR_OVERFLOW
            && (!dst_item.idr_flag || dst_item.packet_end))
        else $error("status flags off the last result");

endmodule

bind avcc_to_annexb_nal_converter_core a2b_checker u_a2b_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_ready (src_ready),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item)
);

`default_nettype wire
